// ----- hdl/bbf_pkg.sv -----
package bbf_pkg;

    localparam int BLOCK_INDEX_BITS = 12;
    localparam int BLOCK_BITS_LOG2  = 9;
    localparam int BLOCK_BITS       = 1 << BLOCK_BITS_LOG2;
    localparam int NUM_BLOCKS       = 1 << BLOCK_INDEX_BITS;

    localparam int HASH_W  = 64;
    localparam int PROBE_W = 5;
    localparam int IDX_W   = 4;
    // stride is bumped when this many low bits are all zero
    localparam int BUMP_BITS = 5;

    localparam logic [PROBE_W-1:0] MAX_PROBES  = 5'd16;
    localparam logic [PROBE_W-1:0] PROBE_RESET = 5'd4;

    typedef struct packed {
        logic clr;
        logic accept;
        logic load;
        logic probe;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic probe_last;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/bbf_in_if.sv -----
interface bbf_in_if;
    logic                      valid;
    logic                      ready;
    logic [bbf_pkg::HASH_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- hdl/bbf_out_if.sv -----
interface bbf_out_if;
    logic                       valid;
    logic                       ready;
    logic [bbf_pkg::PROBE_W-1:0] already_set_count;
    logic                       all_present;

    modport source (output valid, output already_set_count, output all_present, input ready);
    modport sink   (input valid, input already_set_count, input all_present, output ready);
endinterface

// ----- hdl/bbf_ctrl.sv -----
module bbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bbf_pkg::t_sts i_sts,
    output bbf_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_PROBE = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_sts.probe_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                // hold until the result register can take the word
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- hdl/bbf_dp.sv -----
module bbf_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bbf_pkg::t_cmd                 i_cmd,
    output bbf_pkg::t_sts                 o_sts,
    input  logic                          i_cfg_we,
    input  logic [bbf_pkg::PROBE_W-1:0]   i_cfg_wdata,
    input  logic [bbf_pkg::HASH_W-1:0]    i_hash,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bbf_pkg::PROBE_W-1:0]   o_out_count,
    output logic                          o_out_all_present
);

    localparam int IB = bbf_pkg::BLOCK_INDEX_BITS;
    localparam int PB = bbf_pkg::BLOCK_BITS_LOG2;
    localparam int BB = bbf_pkg::BLOCK_BITS;
    localparam int PW = bbf_pkg::PROBE_W;
    localparam int XW = bbf_pkg::IDX_W;

    logic [BB-1:0] mem [bbf_pkg::NUM_BLOCKS];

    logic [PW-1:0] r_probe_count;
    logic [IB-1:0] r_clr_row;
    logic [IB-1:0] r_blk_idx;
    logic [PB-1:0] r_pos;
    logic [PB-1:0] r_stride;
    logic [PW-1:0] r_n;
    logic [PW-1:0] r_cnt;
    logic [XW-1:0] r_idx;
    logic [BB-1:0] r_rd_data;
    logic [BB-1:0] r_blk;
    logic          r_out_valid;
    logic [PW-1:0] r_out_count;
    logic          r_out_all;

    logic [IB-1:0] hash_blk;
    logic [PB-1:0] hash_pos;
    logic [PB-1:0] hash_stride;
    logic [PB-1:0] n_stride;
    logic [PW-1:0] n_n;
    logic          probe_hit;
    logic          mem_we;
    logic [IB-1:0] mem_waddr;
    logic [BB-1:0] mem_wdata;

    assign hash_blk    = i_hash[IB-1:0];
    assign hash_pos    = i_hash[IB +: PB];
    assign hash_stride = i_hash[IB+PB +: PB];

    always_comb begin
        n_stride = hash_stride;
        if (hash_stride[bbf_pkg::BUMP_BITS-1:0] == '0) begin
            n_stride = hash_stride + PB'(1);
        end
        if (r_probe_count == '0) begin
            n_n = PW'(1);
        end else if (r_probe_count > bbf_pkg::MAX_PROBES) begin
            n_n = bbf_pkg::MAX_PROBES;
        end else begin
            n_n = r_probe_count;
        end
    end

    assign probe_hit = r_blk[r_pos];

    assign mem_we    = i_cmd.clr | i_cmd.finish;
    assign mem_waddr = i_cmd.clr ? r_clr_row : r_blk_idx;
    assign mem_wdata = i_cmd.clr ? '0 : r_blk;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[hash_blk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_count <= bbf_pkg::PROBE_RESET;
            r_clr_row     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_probe_count <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_row <= r_clr_row + IB'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_blk_idx <= hash_blk;
            r_pos     <= hash_pos;
            r_stride  <= n_stride;
            r_n       <= n_n;
            r_cnt     <= '0;
            r_idx     <= '0;
        end
        if (i_cmd.load) begin
            r_blk <= r_rd_data;
        end
        if (i_cmd.probe) begin
            // count the bit before setting it, so a repeated position counts
            r_cnt          <= r_cnt + PW'(probe_hit);
            r_blk[r_pos]   <= 1'b1;
            r_pos          <= r_pos + r_stride;
            r_idx          <= r_idx + XW'(1);
        end
        if (i_cmd.finish) begin
            r_out_count <= r_cnt;
            r_out_all   <= (r_cnt == r_n);
        end
    end

    assign o_sts.clr_done   = &r_clr_row;
    assign o_sts.probe_last = ({1'b0, r_idx} == (r_n - PW'(1)));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_out_count       = r_out_count;
    assign o_out_all_present = r_out_all;

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> ({1'b0, r_idx} < r_n))
        else $error("probe index past probe count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (r_cnt <= r_n))
        else $error("hit count exceeds probe count");

    a_accept_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> i_cmd.load)
        else $error("block load did not follow accept");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

endmodule

// ----- hdl/blocked_bloom_filter_insert.sv -----
// Blocked Bloom filter, insert path.
// i_in carries one 64-bit hash per word: low 12 bits pick a 512-bit block,
// the next 9 bits the start position, the next 9 bits the stride.
// o_out returns one word per hash: the count of probes that found their bit
// already set, and all_present when that count equals the probe count.
// i_cfg_we / i_cfg_wdata write probe_count (reset 4, zero acts as one,
// values above sixteen act as sixteen); write it only while idle.
// Each hash runs in turn through these steps:
// the block read is issued at accept, then the working block is loaded,
// one probe per cycle on that block, then write-back and result load,
// held while the output register is full. The next hash is accepted in
// the cycle after write-back, so no hash is taken while one is in flight.
// After reset the block sweeps the filter memory to zero, one block per
// cycle over all 4096 blocks, with i_in.ready low; the config port works throughout.
// A result waits in the output register while the receiver stalls; the next
// hash is still taken and processed, and its write-back holds until the
// output register frees.
module blocked_bloom_filter_insert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bbf_pkg::PROBE_W-1:0] i_cfg_wdata,
    bbf_in_if.sink                      i_in,
    bbf_out_if.source                   o_out
);

    bbf_pkg::t_cmd cmd;
    bbf_pkg::t_sts sts;

    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bbf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_hash            (i_in.hash_value),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_out_count       (o_out.already_set_count),
        .o_out_all_present (o_out.all_present)
    );

endmodule

// ----- tb/tb_blocked_bloom_filter_insert.sv -----
module tb_blocked_bloom_filter_insert;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK_INDEX_BITS = bbf_pkg::BLOCK_INDEX_BITS;
    localparam int BLOCK_BITS_LOG2  = bbf_pkg::BLOCK_BITS_LOG2;
    localparam int BLOCK_BITS       = bbf_pkg::BLOCK_BITS;
    localparam int NUM_BLOCKS       = bbf_pkg::NUM_BLOCKS;
    localparam int HASH_W           = bbf_pkg::HASH_W;
    localparam int PROBE_W          = bbf_pkg::PROBE_W;
    localparam int BUMP_BITS        = bbf_pkg::BUMP_BITS;
    localparam logic [PROBE_W-1:0] MAX_PROBES  = bbf_pkg::MAX_PROBES;
    localparam logic [PROBE_W-1:0] PROBE_RESET = bbf_pkg::PROBE_RESET;

    localparam int WORD_IDX_W   = BLOCK_INDEX_BITS + BLOCK_BITS_LOG2 - 6;
    localparam int FILTER_WORDS = 1 << WORD_IDX_W;
    localparam int STRIDE_LSB   = BLOCK_INDEX_BITS + BLOCK_BITS_LOG2;
    localparam int UPPER_W      = HASH_W - STRIDE_LSB - BLOCK_BITS_LOG2;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HISTORY_MAX  = 256;

    typedef struct packed {
        logic [PROBE_W-1:0] already_set_count;
        logic               all_present;
    } t_insert_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PROBE_W-1:0]  i_cfg_wdata;

    bbf_in_if  in_bus ();
    bbf_out_if out_bus ();

    blocked_bloom_filter_insert dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    bit [63:0]         shadow_filter [0:FILTER_WORDS-1];
    int                probes_per_hash;
    t_insert_result    predicted_results [$];
    logic [HASH_W-1:0] sent_hashes [$];
    int                error_count;
    int                burst_left;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_blocked_bloom_filter_insert: errors");
        $finish;
    end

    // Expected count and flag for one insert; updates the shadow filter.
    function automatic void predict_insert(input logic [HASH_W-1:0] hash);
        logic [BLOCK_INDEX_BITS-1:0] blk;
        logic [BLOCK_BITS_LOG2-1:0]  pos;
        logic [BLOCK_BITS_LOG2-1:0]  stride;
        logic [WORD_IDX_W-1:0]       word_idx;
        int                          hits;
        t_insert_result              res;
        blk    = hash[BLOCK_INDEX_BITS-1:0];
        pos    = hash[BLOCK_INDEX_BITS +: BLOCK_BITS_LOG2];
        stride = hash[STRIDE_LSB +: BLOCK_BITS_LOG2];
        hits   = 0;
        if (stride[BUMP_BITS-1:0] == '0) begin
            stride = stride + 1'b1;
        end
        for (int i = 0; i < probes_per_hash; i++) begin
            word_idx = {blk, pos[BLOCK_BITS_LOG2-1:6]};
            if (shadow_filter[word_idx][pos[5:0]]) begin
                hits++;
            end
            shadow_filter[word_idx][pos[5:0]] = 1'b1;
            pos = pos + stride;
        end
        res.already_set_count = hits[PROBE_W-1:0];
        res.all_present       = (hits == probes_per_hash);
        predicted_results.push_back(res);
    endfunction

    function automatic logic [HASH_W-1:0] make_hash(input int blk, input int pos,
                                                    input int stride,
                                                    input logic [UPPER_W-1:0] upper);
        logic [HASH_W-1:0] h;
        h = '0;
        h[BLOCK_INDEX_BITS-1:0]                = blk[BLOCK_INDEX_BITS-1:0];
        h[BLOCK_INDEX_BITS +: BLOCK_BITS_LOG2] = pos[BLOCK_BITS_LOG2-1:0];
        h[STRIDE_LSB +: BLOCK_BITS_LOG2]       = stride[BLOCK_BITS_LOG2-1:0];
        h[HASH_W-1:STRIDE_LSB+BLOCK_BITS_LOG2] = upper;
        return h;
    endfunction

    // Offer one word; hold valid across a burst, drop it for a gap at burst end.
    task automatic send_hash(input logic [HASH_W-1:0] hash);
        @(negedge i_clk);
        in_bus.valid      = 1'b1;
        in_bus.hash_value = hash;
        do begin
            @(posedge i_clk);
        end while (in_bus.ready !== 1'b1);
        predict_insert(hash);
        sent_hashes.push_back(hash);
        if (sent_hashes.size() > HISTORY_MAX) begin
            void'(sent_hashes.pop_front());
        end
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            in_bus.valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_probe_count(input logic [PROBE_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        // zero acts as one probe, anything above the maximum saturates
        if (value == '0) begin
            probes_per_hash = 1;
        end else if (value > MAX_PROBES) begin
            probes_per_hash = int'(MAX_PROBES);
        end else begin
            probes_per_hash = int'(value);
        end
    endtask

    always @(posedge i_clk) begin
        t_insert_result exp_res;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                $error("result word with nothing expected: count %0d flag %0b",
                       out_bus.already_set_count, out_bus.all_present);
                error_count++;
            end else begin
                exp_res = predicted_results.pop_front();
                if (out_bus.already_set_count !== exp_res.already_set_count) begin
                    $error("already_set_count expected %0d actual %0d",
                           exp_res.already_set_count, out_bus.already_set_count);
                    error_count++;
                end
                if (out_bus.all_present !== exp_res.all_present) begin
                    $error("all_present expected %0b actual %0b",
                           exp_res.all_present, out_bus.all_present);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stall patterns that change every stretch.
    initial begin
        int mode;
        int stretch;
        int period;
        out_bus.ready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 4);
            stretch = $urandom_range(8, 80);
            period  = $urandom_range(2, 9);
            for (int i = 0; i < stretch; i++) begin
                @(negedge i_clk);
                case (mode)
                    0: out_bus.ready = 1'b1;
                    1: out_bus.ready = ($urandom_range(0, 3) != 0);
                    2: out_bus.ready = ($urandom_range(0, 3) == 0);
                    3: out_bus.ready = ((i % period) == 0);
                    default: out_bus.ready = (i >= stretch / 2);
                endcase
            end
        end
    end

    task automatic apply_reset();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_bus.valid      = 1'b0;
        in_bus.hash_value = '0;
        error_count       = 0;
        burst_left        = 1;
        probes_per_hash   = int'(PROBE_RESET);
        for (int i = 0; i < FILTER_WORDS; i++) begin
            shadow_filter[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    task automatic test_reset_defaults();
        send_hash('0);
        send_hash('1);
        send_hash('0);
        send_hash(make_hash(NUM_BLOCKS - 1, BLOCK_BITS - 1, 32, '0));
    endtask

    task automatic test_probe_limits();
        write_probe_count('0);
        send_hash(make_hash(7, 100, 3, '0));
        send_hash(make_hash(7, 100, 3, '0));
        write_probe_count('1);
        send_hash(make_hash(8, 5, 0, '1));
        send_hash(make_hash(8, 5, 0, '0));
        write_probe_count(MAX_PROBES);
        send_hash(make_hash(9, 0, 1, '0));
        write_probe_count(MAX_PROBES + 1'b1);
        send_hash(make_hash(9, 0, 1, '0));
        write_probe_count(5'd1);
        send_hash(make_hash(10, 0, 0, '0));
    endtask

    task automatic test_hash_fields();
        logic [UPPER_W-1:0] upper;
        upper = UPPER_W'({$urandom, $urandom});
        write_probe_count(MAX_PROBES);
        // stride of zero bumps to one; start at the top of the block to wrap
        send_hash(make_hash(0, BLOCK_BITS - 1, 0, '0));
        send_hash(make_hash(NUM_BLOCKS - 1, BLOCK_BITS - 1, BLOCK_BITS - 1, '0));
        send_hash(make_hash(NUM_BLOCKS - 1, 64, 256, '0));
        // bits above the stride field must not change which bits are probed
        send_hash(make_hash(1234, 321, 77, upper));
        send_hash(make_hash(1234, 321, 77, ~upper));
    endtask

    task automatic test_random_traffic(input logic [PROBE_W-1:0] setting, input int count);
        logic [HASH_W-1:0] hash;
        int                kind;
        write_probe_count(setting);
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2 || sent_hashes.size() == 0) begin
                hash = {$urandom, $urandom};
            end else if (kind <= 5) begin
                // revisit an earlier hash, sometimes with different unused bits
                hash = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
                if (kind == 5) begin
                    hash[HASH_W-1:STRIDE_LSB+BLOCK_BITS_LOG2] = UPPER_W'({$urandom, $urandom});
                end
            end else begin
                // crowd a few blocks so hits build up
                hash = {$urandom, $urandom};
                hash[BLOCK_INDEX_BITS-1:0] = ($urandom_range(0, 4) == 0)
                                             ? BLOCK_INDEX_BITS'(NUM_BLOCKS - 1)
                                             : BLOCK_INDEX_BITS'($urandom_range(0, 3));
                if (kind == 9) begin
                    hash[STRIDE_LSB +: BUMP_BITS] = '0;
                end
            end
            send_hash(hash);
        end
    endtask

    initial begin
        apply_reset();
        test_reset_defaults();
        test_probe_limits();
        test_hash_fields();
        test_random_traffic(5'd1, 220);
        test_random_traffic(MAX_PROBES, 220);
        test_random_traffic(PROBE_W'($urandom_range(2, 15)), 220);
        test_random_traffic('1, 220);
        test_random_traffic('0, 150);
        test_random_traffic(PROBE_W'($urandom_range(17, 30)), 160);
        test_random_traffic(PROBE_RESET, 160);
        wait_idle();
        if (error_count == 0) begin
            $display("tb_blocked_bloom_filter_insert: clean");
        end else begin
            $display("tb_blocked_bloom_filter_insert: errors");
        end
        $finish;
    end

endmodule
